>>> hdl/fqh_pkg.sv
//------------------------------------------------------------------------------
// fqh_pkg
// Shared constants, types and the star pair table for the quad hash block.
//------------------------------------------------------------------------------
`default_nettype none

package fqh_pkg;

    // default geometry
    localparam int C_COORD_WIDTH    = 24;
    localparam int C_HASH_FRAC_BITS = 16;

    // star and pair counts of one quad
    localparam int C_STARS = 4;
    localparam int C_PAIRS = 6;

    typedef logic [1:0] t_idx;

    // role of each star: a, b the far pair, c, d the inner stars in index order
    typedef struct packed {
        t_idx d;
        t_idx c;
        t_idx b;
        t_idx a;
    } t_quad;

    // pair number (scan order) to star roles
    function automatic t_quad pair_quad(input logic [2:0] k);
        t_quad q;
        case (k)
            3'd0:    q = '{a: 2'd1, b: 2'd0, c: 2'd2, d: 2'd3};
            3'd1:    q = '{a: 2'd2, b: 2'd0, c: 2'd1, d: 2'd3};
            3'd2:    q = '{a: 2'd2, b: 2'd1, c: 2'd0, d: 2'd3};
            3'd3:    q = '{a: 2'd3, b: 2'd0, c: 2'd1, d: 2'd2};
            3'd4:    q = '{a: 2'd3, b: 2'd1, c: 2'd0, d: 2'd2};
            3'd5:    q = '{a: 2'd3, b: 2'd2, c: 2'd0, d: 2'd1};
            default: q = '{a: 2'd1, b: 2'd0, c: 2'd2, d: 2'd3};
        endcase
        return q;
    endfunction

    // first star of a pair
    function automatic t_idx pair_hi(input logic [2:0] k);
        t_quad q;
        q = pair_quad(k);
        return q.a;
    endfunction

    // second star of a pair
    function automatic t_idx pair_lo(input logic [2:0] k);
        t_quad q;
        q = pair_quad(k);
        return q.b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/four_star_quad_hash.sv
//------------------------------------------------------------------------------
// four_star_quad_hash
// Geometric hash of a quad of four stars: far pair, circle test, projection
// of the inner stars into the A=(0,0), B=(1,1) frame, symmetry breaking.
//------------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                       | tuser
//  s       | in  | star0_x star0_y .. star3_x star3_y          | -
//  m       | out | x_first y_first x_second y_second a b c d   | hash_valid
//
//  One request per cycle while the output register is not stalled.
//  The quotient pipeline (one bit per stage) sets most of the depth.
//  All stages advance together; the pipe holds when the output register is
//  full and not taken, so s_tready follows m_tready of the output register.
//  Synchronous active-low reset clears the valid bits only.
//------------------------------------------------------------------------------
`default_nettype none

module four_star_quad_hash import fqh_pkg::*; #(
    parameter int COORD_WIDTH    = C_COORD_WIDTH,
    parameter int HASH_FRAC_BITS = C_HASH_FRAC_BITS
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    // star0_x, star0_y, star1_x, star1_y, star2_x, star2_y, star3_x, star3_y
    input  wire logic [((8*COORD_WIDTH+7)/8)*8-1:0]            i_s_tdata,
    input  wire logic                                          i_s_tvalid,
    output logic                                               o_s_tready,
    // hash_x_first, hash_y_first, hash_x_second, hash_y_second,
    // index_a, index_b, index_c, index_d
    output logic [((4*(HASH_FRAC_BITS+2)+8+7)/8)*8-1:0]        o_m_tdata,
    // hash_valid
    output logic                                               o_m_tuser,
    output logic                                               o_m_tvalid,
    input  wire logic                                          i_m_tready
);

    localparam int CW    = COORD_WIDTH;
    localparam int F     = HASH_FRAC_BITS;
    localparam int OUT_W = ((4*(F+2)+8+7)/8)*8;
    localparam int DW    = CW + 1;       // coordinate difference
    localparam int SQW   = 2 * CW;       // square of a difference
    localparam int LW    = 2 * CW + 1;   // squared pair distance
    localparam int SW    = CW + 2;       // frame axes and circle offsets
    localparam int EQW   = 2 * CW + 2;   // square of a circle offset
    localparam int CSW   = 2 * CW + 3;   // circle distance
    localparam int PW    = 2 * CW + 2;   // projection product
    localparam int NW    = 2 * CW + 3;   // projection numerator
    localparam int MW    = 2 * CW + 2;   // numerator magnitude
    localparam int HW    = F + 2;        // hash field
    localparam int QW    = F + 3;        // quotient with one extra bit for rounding
    localparam int DLAT  = QW + 1;       // divider depth

    localparam logic [QW-1:0]        Q_LIM    = QW'(1) << (F + 1);
    localparam logic [QW-1:0]        Q_LIM_M1 = Q_LIM - QW'(1);
    localparam logic signed [HW-1:0] H_MAX    = {1'b0, {(HW-1){1'b1}}};
    localparam logic signed [HW-1:0] H_MIN    = {1'b1, {(HW-1){1'b0}}};
    localparam logic signed [HW:0]   E_ONE    = (HW+1)'(1) << F;
    localparam logic signed [HW:0]   E_MAX    = {2'b00, {(HW-1){1'b1}}};

    typedef struct packed {
        logic       hv;
        logic       zero;
        logic [3:0] neg;
        t_quad      q;
    } t_side;

    logic w_en;

    // flow control: whole pipe steps unless the output request is stalled
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en && i_rst_n;

    // ---------------- stage 1: input capture
    logic          r1_v;
    logic [CW-1:0] r1_x [C_STARS];
    logic [CW-1:0] r1_y [C_STARS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < C_STARS; i++) begin
                r1_x[i] <= i_s_tdata[(2*i)*CW +: CW];
                r1_y[i] <= i_s_tdata[(2*i+1)*CW +: CW];
            end
        end
    end

    // ---------------- stage 2: pair differences
    logic                 r2_v;
    logic [CW-1:0]        r2_x  [C_STARS];
    logic [CW-1:0]        r2_y  [C_STARS];
    logic signed [DW-1:0] r2_dx [C_PAIRS];
    logic signed [DW-1:0] r2_dy [C_PAIRS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x <= r1_x;
            r2_y <= r1_y;
            for (int k = 0; k < C_PAIRS; k++) begin
                r2_dx[k] <= signed'({1'b0, r1_x[pair_lo(3'(k))]})
                          - signed'({1'b0, r1_x[pair_hi(3'(k))]});
                r2_dy[k] <= signed'({1'b0, r1_y[pair_lo(3'(k))]})
                          - signed'({1'b0, r1_y[pair_hi(3'(k))]});
            end
        end
    end

    // ---------------- stage 3: squares
    logic                   r3_v;
    logic [CW-1:0]          r3_x  [C_STARS];
    logic [CW-1:0]          r3_y  [C_STARS];
    logic [SQW-1:0]         r3_sx [C_PAIRS];
    logic [SQW-1:0]         r3_sy [C_PAIRS];
    logic signed [2*DW-1:0] w3_px [C_PAIRS];
    logic signed [2*DW-1:0] w3_py [C_PAIRS];

    always_comb begin
        for (int k = 0; k < C_PAIRS; k++) begin
            w3_px[k] = r2_dx[k] * r2_dx[k];
            w3_py[k] = r2_dy[k] * r2_dy[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_x <= r2_x;
            r3_y <= r2_y;
            for (int k = 0; k < C_PAIRS; k++) begin
                r3_sx[k] <= w3_px[k][SQW-1:0];
                r3_sy[k] <= w3_py[k][SQW-1:0];
            end
        end
    end

    // ---------------- stage 4: squared distances
    logic          r4_v;
    logic [CW-1:0] r4_x [C_STARS];
    logic [CW-1:0] r4_y [C_STARS];
    logic [LW-1:0] r4_d [C_PAIRS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_x <= r3_x;
            r4_y <= r3_y;
            for (int k = 0; k < C_PAIRS; k++) begin
                r4_d[k] <= LW'(r3_sx[k]) + LW'(r3_sy[k]);
            end
        end
    end

    // ---------------- stage 5: first round of the max search (later wins only if greater)
    logic          r5_v;
    logic [CW-1:0] r5_x [C_STARS];
    logic [CW-1:0] r5_y [C_STARS];
    logic [LW-1:0] r5_d [3];
    logic [2:0]    r5_k [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_x <= r4_x;
            r5_y <= r4_y;
            for (int g = 0; g < 3; g++) begin
                if (r4_d[2*g+1] > r4_d[2*g]) begin
                    r5_d[g] <= r4_d[2*g+1];
                    r5_k[g] <= 3'(2*g + 1);
                end else begin
                    r5_d[g] <= r4_d[2*g];
                    r5_k[g] <= 3'(2*g);
                end
            end
        end
    end

    // ---------------- stage 6: final round, star roles
    logic          r6_v;
    logic [CW-1:0] r6_x [C_STARS];
    logic [CW-1:0] r6_y [C_STARS];
    logic [LW-1:0] r6_ab2;
    t_quad         r6_q;
    logic [1:0]    w6_win;

    always_comb begin
        if (r5_d[0] >= r5_d[1] && r5_d[0] >= r5_d[2]) begin
            w6_win = 2'd0;
        end else if (r5_d[1] >= r5_d[2]) begin
            w6_win = 2'd1;
        end else begin
            w6_win = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_x <= r5_x;
            r6_y <= r5_y;
            case (w6_win)
                2'd0: begin
                    r6_ab2 <= r5_d[0];
                    r6_q   <= pair_quad(r5_k[0]);
                end
                2'd1: begin
                    r6_ab2 <= r5_d[1];
                    r6_q   <= pair_quad(r5_k[1]);
                end
                default: begin
                    r6_ab2 <= r5_d[2];
                    r6_q   <= pair_quad(r5_k[2]);
                end
            endcase
        end
    end

    // ---------------- stage 7: pick stars, frame axes and offsets
    logic                 r7_v;
    logic [LW-1:0]        r7_ab2;
    t_quad                r7_q;
    logic signed [SW-1:0] r7_s;
    logic signed [SW-1:0] r7_t;
    logic signed [DW-1:0] r7_vx [2];
    logic signed [DW-1:0] r7_vy [2];
    logic signed [SW-1:0] r7_ex [2];
    logic signed [SW-1:0] r7_ey [2];
    logic signed [SW-1:0] w7_ax, w7_ay, w7_bx, w7_by;
    logic signed [SW-1:0] w7_cx [2];
    logic signed [SW-1:0] w7_cy [2];

    always_comb begin
        w7_ax = '0;
        w7_ay = '0;
        w7_bx = '0;
        w7_by = '0;
        w7_cx = '{default: '0};
        w7_cy = '{default: '0};
        for (int j = 0; j < C_STARS; j++) begin
            if (r6_q.a == t_idx'(j)) begin
                w7_ax = signed'({2'b00, r6_x[j]});
                w7_ay = signed'({2'b00, r6_y[j]});
            end
            if (r6_q.b == t_idx'(j)) begin
                w7_bx = signed'({2'b00, r6_x[j]});
                w7_by = signed'({2'b00, r6_y[j]});
            end
            if (r6_q.c == t_idx'(j)) begin
                w7_cx[0] = signed'({2'b00, r6_x[j]});
                w7_cy[0] = signed'({2'b00, r6_y[j]});
            end
            if (r6_q.d == t_idx'(j)) begin
                w7_cx[1] = signed'({2'b00, r6_x[j]});
                w7_cy[1] = signed'({2'b00, r6_y[j]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_ab2 <= r6_ab2;
            r7_q   <= r6_q;
            r7_s   <= (w7_bx + w7_by) - (w7_ax + w7_ay);
            r7_t   <= (w7_by - w7_bx) - (w7_ay - w7_ax);
            for (int i = 0; i < 2; i++) begin
                r7_vx[i] <= DW'(w7_cx[i] - w7_ax);
                r7_vy[i] <= DW'(w7_cy[i] - w7_ay);
                r7_ex[i] <= (w7_cx[i] <<< 1) - w7_ax - w7_bx;
                r7_ey[i] <= (w7_cy[i] <<< 1) - w7_ay - w7_by;
            end
        end
    end

    // ---------------- stage 8: products
    logic                      r8_v;
    logic [LW-1:0]             r8_ab2;
    t_quad                     r8_q;
    logic signed [PW-1:0]      r8_xs [2];
    logic signed [PW-1:0]      r8_yt [2];
    logic signed [PW-1:0]      r8_xt [2];
    logic signed [PW-1:0]      r8_ys [2];
    logic [EQW-1:0]            r8_ex2 [2];
    logic [EQW-1:0]            r8_ey2 [2];
    logic signed [DW+SW-1:0]   w8_xs [2];
    logic signed [DW+SW-1:0]   w8_yt [2];
    logic signed [DW+SW-1:0]   w8_xt [2];
    logic signed [DW+SW-1:0]   w8_ys [2];
    logic signed [2*SW-1:0]    w8_ex2 [2];
    logic signed [2*SW-1:0]    w8_ey2 [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w8_xs[i]  = r7_vx[i] * r7_s;
            w8_yt[i]  = r7_vy[i] * r7_t;
            w8_xt[i]  = r7_vx[i] * r7_t;
            w8_ys[i]  = r7_vy[i] * r7_s;
            w8_ex2[i] = r7_ex[i] * r7_ex[i];
            w8_ey2[i] = r7_ey[i] * r7_ey[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_ab2 <= r7_ab2;
            r8_q   <= r7_q;
            for (int i = 0; i < 2; i++) begin
                r8_xs[i]  <= w8_xs[i][PW-1:0];
                r8_yt[i]  <= w8_yt[i][PW-1:0];
                r8_xt[i]  <= w8_xt[i][PW-1:0];
                r8_ys[i]  <= w8_ys[i][PW-1:0];
                r8_ex2[i] <= w8_ex2[i][EQW-1:0];
                r8_ey2[i] <= w8_ey2[i][EQW-1:0];
            end
        end
    end

    // ---------------- stage 9: numerators and circle distances
    // lanes: 0 x of c, 1 y of c, 2 x of d, 3 y of d
    logic                 r9_v;
    logic [LW-1:0]        r9_ab2;
    t_quad                r9_q;
    logic signed [NW-1:0] r9_n  [C_STARS];
    logic [CSW-1:0]       r9_cd [2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_ab2 <= r8_ab2;
            r9_q   <= r8_q;
            for (int i = 0; i < 2; i++) begin
                r9_n[2*i]   <= signed'({r8_xs[i][PW-1], r8_xs[i]})
                             + signed'({r8_yt[i][PW-1], r8_yt[i]});
                r9_n[2*i+1] <= signed'({r8_ys[i][PW-1], r8_ys[i]})
                             - signed'({r8_xt[i][PW-1], r8_xt[i]});
                r9_cd[i]    <= CSW'(r8_ex2[i]) + CSW'(r8_ey2[i]);
            end
        end
    end

    // ---------------- stage 10: circle test, sign and magnitude
    logic                      r10_v;
    logic [LW-1:0]             r10_ab2;
    logic [C_STARS-1:0][MW-1:0] r10_mag;
    t_side                     r10_sd;
    logic signed [NW-1:0]      w10_ng [C_STARS];

    always_comb begin
        for (int l = 0; l < C_STARS; l++) begin
            w10_ng[l] = -r9_n[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_ab2     <= r9_ab2;
            r10_sd.q    <= r9_q;
            r10_sd.zero <= r9_ab2 == '0;
            r10_sd.hv   <= CSW'(r9_ab2) >= r9_cd[0] && CSW'(r9_ab2) >= r9_cd[1];
            for (int l = 0; l < C_STARS; l++) begin
                r10_sd.neg[l] <= r9_n[l][NW-1];
                r10_mag[l]    <= r9_n[l][NW-1] ? w10_ng[l][MW-1:0] : r9_n[l][MW-1:0];
            end
        end
    end

    // ---------------- divider, with side data alongside
    logic [C_STARS-1:0][QW-1:0] w_quo;
    logic [C_STARS-1:0]         w_ovf;
    logic [DLAT-1:0]            r_dl_v;
    t_side                      r_dl_sd [DLAT];

    fqh_div #(
        .LANES     (C_STARS),
        .NUM_W     (MW),
        .DEN_W     (LW),
        .Q_W       (QW),
        .PRE_SHIFT (F + 1)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r10_mag),
        .i_den  (r10_ab2),
        .o_quo  (w_quo),
        .o_ovf  (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_sd[0] <= r10_sd;
            for (int s = 1; s < DLAT; s++) begin
                r_dl_sd[s] <= r_dl_sd[s-1];
            end
        end
    end

    // ---------------- stage 11: round half away, apply sign, saturate
    logic                 r11_v;
    logic                 r11_hv;
    t_quad                r11_q;
    logic signed [HW-1:0] r11_h [C_STARS];
    logic [QW-1:0]        w11_r [C_STARS];
    logic [QW:0]          w11_s [C_STARS];
    logic [QW-1:0]        w11_n [C_STARS];
    t_side                w11_sd;

    assign w11_sd = r_dl_sd[DLAT-1];

    always_comb begin
        for (int l = 0; l < C_STARS; l++) begin
            w11_s[l] = (QW+1)'(w_quo[l]) + (QW+1)'(1);
            w11_r[l] = w11_s[l][QW:1];
            w11_n[l] = -w11_r[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_hv <= w11_sd.hv;
            r11_q  <= w11_sd.q;
            for (int l = 0; l < C_STARS; l++) begin
                if (!w11_sd.hv || w11_sd.zero) begin
                    r11_h[l] <= '0;
                end else if (w11_sd.neg[l]) begin
                    r11_h[l] <= (w_ovf[l] || w11_r[l] > Q_LIM) ? H_MIN : w11_n[l][HW-1:0];
                end else begin
                    r11_h[l] <= (w_ovf[l] || w11_r[l] > Q_LIM_M1) ? H_MAX : w11_r[l][HW-1:0];
                end
            end
        end
    end

    // ---------------- stage 12: mirror when xc + xd exceeds one
    logic                 r12_v;
    logic                 r12_hv;
    t_quad                r12_q;
    logic signed [HW-1:0] r12_h [C_STARS];
    logic signed [HW:0]   w12_sum;
    logic signed [HW:0]   w12_m [C_STARS];
    logic                 w12_mir;

    always_comb begin
        w12_sum = signed'({r11_h[0][HW-1], r11_h[0]}) + signed'({r11_h[2][HW-1], r11_h[2]});
        w12_mir = w12_sum > E_ONE;
        for (int l = 0; l < C_STARS; l++) begin
            w12_m[l] = E_ONE - signed'({r11_h[l][HW-1], r11_h[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_hv     <= r11_hv;
            r12_q.c    <= r11_q.c;
            r12_q.d    <= r11_q.d;
            r12_q.a    <= w12_mir ? r11_q.b : r11_q.a;
            r12_q.b    <= w12_mir ? r11_q.a : r11_q.b;
            for (int l = 0; l < C_STARS; l++) begin
                if (!w12_mir) begin
                    r12_h[l] <= r11_h[l];
                end else begin
                    r12_h[l] <= (w12_m[l] > E_MAX) ? H_MAX : w12_m[l][HW-1:0];
                end
            end
        end
    end

    // ---------------- stage 13: order inner stars by x, output register
    logic                 r13_v;
    logic                 r13_hv;
    t_quad                r13_q;
    logic signed [HW-1:0] r13_h [C_STARS];
    logic                 w13_swp;

    assign w13_swp = r12_h[0] > r12_h[2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r13_hv  <= r12_hv;
            r13_q.a <= r12_q.a;
            r13_q.b <= r12_q.b;
            if (w13_swp) begin
                r13_q.c  <= r12_q.d;
                r13_q.d  <= r12_q.c;
                r13_h[0] <= r12_h[2];
                r13_h[1] <= r12_h[3];
                r13_h[2] <= r12_h[0];
                r13_h[3] <= r12_h[1];
            end else begin
                r13_q.c <= r12_q.c;
                r13_q.d <= r12_q.d;
                r13_h   <= r12_h;
            end
        end
    end

    // ---------------- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r6_v   <= 1'b0;
            r7_v   <= 1'b0;
            r8_v   <= 1'b0;
            r9_v   <= 1'b0;
            r10_v  <= 1'b0;
            r_dl_v <= '0;
            r11_v  <= 1'b0;
            r12_v  <= 1'b0;
            r13_v  <= 1'b0;
        end else if (w_en) begin
            r1_v   <= i_s_tvalid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r6_v   <= r5_v;
            r7_v   <= r6_v;
            r8_v   <= r7_v;
            r9_v   <= r8_v;
            r10_v  <= r9_v;
            r_dl_v <= {r_dl_v[DLAT-2:0], r10_v};
            r11_v  <= r_dl_v[DLAT-1];
            r12_v  <= r11_v;
            r13_v  <= r12_v;
        end
    end

    // ---------------- output request
    assign o_m_tvalid = r13_v;
    assign o_m_tuser  = r13_hv;
    assign o_m_tdata  = OUT_W'({r13_q.d, r13_q.c, r13_q.b, r13_q.a,
                                r13_h[3], r13_h[2], r13_h[1], r13_h[0]});

endmodule

`default_nettype wire

>>> hdl/fqh_div.sv
//------------------------------------------------------------------------------
// fqh_div
// Pipelined restoring divider, several dividends over one shared divisor.
// One quotient bit per stage, plus an entry stage that flags overflow.
//------------------------------------------------------------------------------
`default_nettype none

module fqh_div import fqh_pkg::*; #(
    parameter int LANES     = C_STARS,
    parameter int NUM_W     = 2 * C_COORD_WIDTH + 2,
    parameter int DEN_W     = 2 * C_COORD_WIDTH + 1,
    parameter int Q_W       = C_HASH_FRAC_BITS + 3,
    parameter int PRE_SHIFT = C_HASH_FRAC_BITS + 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [LANES-1:0][NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]                i_den,
    output logic      [LANES-1:0][Q_W-1:0]       o_quo,
    output logic      [LANES-1:0]                o_ovf
);

    localparam int REM_W = NUM_W + PRE_SHIFT;

    logic [LANES-1:0][REM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0]            r_den [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_quo [Q_W+1];
    logic [LANES-1:0]            r_ovf [Q_W+1];

    // entry stage: scale dividend, flag quotients that do not fit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= REM_W'(i_num[l]) << PRE_SHIFT;
                r_quo[0][l] <= '0;
                r_ovf[0][l] <= ((REM_W'(i_num[l]) << PRE_SHIFT) >> Q_W) >= REM_W'(i_den);
            end
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int P = Q_W - 1 - s;
        logic [REM_W-1:0] w_dsh;
        logic [LANES-1:0] w_ge;

        assign w_dsh = REM_W'(r_den[s]) << P;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_ge[l] = r_rem[s][l] >= w_dsh;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[s+1] <= r_ovf[s];
                for (int l = 0; l < LANES; l++) begin
                    r_quo[s+1][l] <= r_quo[s][l] | (Q_W'(w_ge[l]) << P);
                end
            end
        end

        if (s < Q_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s+1] <= r_den[s];
                    for (int l = 0; l < LANES; l++) begin
                        r_rem[s+1][l] <= w_ge[l] ? r_rem[s][l] - w_dsh : r_rem[s][l];
                    end
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

`default_nettype wire

>>> bench/tb_four_star_quad_hash.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_four_star_quad_hash
// Self-checking bench for the quad hash block. Quads of four stars stream in.
// A scoreboard computes each hash (far pair, circle test, exact rounded
// projection, mirror and C/D order) and checks every output request in order.
// Stimulus is mostly well-formed quads with inner stars near the circle,
// plus full-range and tiny-range noise. Both sides idle at random.
//------------------------------------------------------------------------------

import fqh_pkg::*;

localparam int CW      = C_COORD_WIDTH;
localparam int HF      = C_HASH_FRAC_BITS;
localparam int HW      = HF + 2;
localparam int S_BITS  = ((8*CW+7)/8)*8;
localparam int M_BITS  = ((4*HW+8+7)/8)*8;
localparam longint HASH_ONE = longint'(1) << HF;
localparam longint HASH_LIM = longint'(1) << (HF + 1);

typedef struct packed {
    logic                 valid;
    logic signed [HW-1:0] xf, yf, xs, ys;
    t_idx                 a, b, c, d;
} t_hash_res;

// expected hashes and the checker
class quad_scoreboard;
    t_hash_res pending_hashes[$];
    int        n_mismatch = 0;
    int        n_checked  = 0;
    int        n_valid    = 0;

    // exact projection, rounded half away from zero, saturated
    function longint proj(longint vx, longint vy, longint px, longint py,
                          logic [127:0] den);
        logic signed [127:0] num;
        logic [127:0]        mag, q, r;
        num = 128'(vx) * 128'(px) + 128'(vy) * 128'(py);
        mag = num[127] ? -num : num;
        mag = mag << HF;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q = q + 1;
        if (num[127]) begin
            if (q > 128'(HASH_LIM)) return -HASH_LIM;
            return -longint'(q);
        end
        if (q > 128'(HASH_LIM - 1)) return HASH_LIM - 1;
        return longint'(q);
    endfunction

    function longint sat(longint v);
        if (v > HASH_LIM - 1) return HASH_LIM - 1;
        if (v < -HASH_LIM) return -HASH_LIM;
        return v;
    endfunction

    function t_hash_res quad_hash_of(logic [S_BITS-1:0] q);
        longint sx[4], sy[4];
        longint best, pair_d2, dx, dy, ab2, ec, ed;
        longint xc, yc, xd, yd, t;
        int     a, b, c, d, ti;
        logic   ok;
        t_hash_res r;
        best = 0; a = 1; b = 0; c = -1; d = -1;
        xc = 0; yc = 0; xd = 0; yd = 0;
        for (int i = 0; i < 4; i++) begin
            sx[i] = longint'(q[48*i +: CW]);
            sy[i] = longint'(q[48*i+24 +: CW]);
        end
        // far pair, first in scan order on ties
        for (int i = 1; i < 4; i++)
            for (int j = 0; j < i; j++) begin
                pair_d2 = (sx[j]-sx[i])*(sx[j]-sx[i]) + (sy[j]-sy[i])*(sy[j]-sy[i]);
                if ((i == 1) || pair_d2 > best) begin
                    a = i; b = j; best = pair_d2;
                end
            end
        for (int i = 0; i < 4; i++)
            if (i != a && i != b) begin
                if (c < 0) c = i; else d = i;
            end
        ab2 = best;
        ec = (2*sx[c]-sx[a]-sx[b])**2 + (2*sy[c]-sy[a]-sy[b])**2;
        ed = (2*sx[d]-sx[a]-sx[b])**2 + (2*sy[d]-sy[a]-sy[b])**2;
        ok = (ab2 >= ec) && (ab2 >= ed);
        r.valid = ok;
        if (ok) begin
            dx = sx[b] - sx[a];
            dy = sy[b] - sy[a];
            if (ab2 != 0) begin
                xc = proj(sx[c]-sx[a], sy[c]-sy[a], dx+dy, dy-dx, 128'(ab2));
                yc = proj(sx[c]-sx[a], sy[c]-sy[a], dx-dy, dx+dy, 128'(ab2));
                xd = proj(sx[d]-sx[a], sy[d]-sy[a], dx+dy, dy-dx, 128'(ab2));
                yd = proj(sx[d]-sx[a], sy[d]-sy[a], dx-dy, dx+dy, 128'(ab2));
            end
            // mirror symmetry
            if (xc + xd > HASH_ONE) begin
                ti = a; a = b; b = ti;
                xc = sat(HASH_ONE - xc); yc = sat(HASH_ONE - yc);
                xd = sat(HASH_ONE - xd); yd = sat(HASH_ONE - yd);
            end
            // inner stars ordered by X
            if (xc > xd) begin
                ti = c; c = d; d = ti;
                t = xc; xc = xd; xd = t;
                t = yc; yc = yd; yd = t;
            end
        end
        r.xf = HW'(xc); r.yf = HW'(yc); r.xs = HW'(xd); r.ys = HW'(yd);
        r.a = t_idx'(a); r.b = t_idx'(b); r.c = t_idx'(c); r.d = t_idx'(d);
        return r;
    endfunction

    function void note_quad(logic [S_BITS-1:0] q);
        pending_hashes.push_back(quad_hash_of(q));
    endfunction

    function void check_hash(logic [M_BITS-1:0] data, logic user);
        t_hash_res e, g;
        g.valid = user;
        g.xf = data[0 +: HW];      g.yf = data[HW +: HW];
        g.xs = data[2*HW +: HW];   g.ys = data[3*HW +: HW];
        g.a = data[4*HW +: 2];     g.b = data[4*HW+2 +: 2];
        g.c = data[4*HW+4 +: 2];   g.d = data[4*HW+6 +: 2];
        n_checked++;
        if (pending_hashes.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("ERROR: unexpected hash request %h user %b", data, user);
            return;
        end
        e = pending_hashes.pop_front();
        if (e.valid) n_valid++;
        if (e != g) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display({"ERROR: hash #%0d exp v%b x1 %0d y1 %0d x2 %0d y2 %0d ",
                          "abcd %0d%0d%0d%0d / got v%b x1 %0d y1 %0d x2 %0d y2 %0d ",
                          "abcd %0d%0d%0d%0d"}, n_checked,
                         e.valid, e.xf, e.yf, e.xs, e.ys, e.a, e.b, e.c, e.d,
                         g.valid, g.xf, g.yf, g.xs, g.ys, g.a, g.b, g.c, g.d);
        end
    endfunction
endclass

module tb_four_star_quad_hash;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [S_BITS-1:0] i_s_tdata = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [M_BITS-1:0] o_m_tdata;
    logic              o_m_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;

    quad_scoreboard sb = new();
    int  hold_cycles = 0;
    int  n_sent = 0;

    four_star_quad_hash dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_quad(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_hash(o_m_tdata, o_m_tuser);
        end
    end

    // receiver stalls: four ready patterns taken in turn, long hold on request
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 128) % 4;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            case (phase)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(1, 0) == 1);
                2: i_m_tready <= ($urandom_range(3, 0) == 0);
                default: i_m_tready <= ($urandom_range(7, 0) != 0);
            endcase
        end
    end

    function automatic logic [S_BITS-1:0] pack_quad(longint x[4], longint y[4]);
        logic [S_BITS-1:0] q;
        q = '0;
        for (int i = 0; i < 4; i++) begin
            q[48*i +: CW]    = x[i][CW-1:0];
            q[48*i+24 +: CW] = y[i][CW-1:0];
        end
        return q;
    endfunction

    // far pair with two inner stars near the middle, in shuffled slots
    function automatic logic [S_BITS-1:0] inner_quad();
        longint px[4], py[4], x[4], y[4];
        longint m, spread;
        int     k, p, tmp;
        int     perm[4];
        k = $urandom_range(21, 2);
        px[0] = $urandom_range(24'hC00000, 24'h400000);
        py[0] = $urandom_range(24'hC00000, 24'h400000);
        px[1] = px[0] + longint'($urandom_range(2**(k+1), 0)) - 2**k;
        py[1] = py[0] + longint'($urandom_range(2**(k+1), 0)) - 2**k;
        m = (px[1] > px[0]) ? px[1] - px[0] : px[0] - px[1];
        if (((py[1] > py[0]) ? py[1] - py[0] : py[0] - py[1]) > m)
            m = (py[1] > py[0]) ? py[1] - py[0] : py[0] - py[1];
        // mostly well inside, sometimes out to the rim and beyond
        spread = ($urandom_range(3, 0) == 0) ? m / 2 + 1 : m / 4 + 1;
        for (int i = 2; i < 4; i++) begin
            px[i] = (px[0] + px[1]) / 2 + longint'($urandom_range(2*spread, 0)) - spread;
            py[i] = (py[0] + py[1]) / 2 + longint'($urandom_range(2*spread, 0)) - spread;
        end
        for (int i = 0; i < 4; i++) perm[i] = i;
        for (int i = 3; i > 0; i--) begin
            p = $urandom_range(i, 0);
            tmp = perm[i]; perm[i] = perm[p]; perm[p] = tmp;
        end
        for (int i = 0; i < 4; i++) begin
            x[perm[i]] = px[i];
            y[perm[i]] = py[i];
        end
        return pack_quad(x, y);
    endfunction

    function automatic logic [S_BITS-1:0] noise_quad(logic tiny);
        longint x[4], y[4];
        for (int i = 0; i < 4; i++) begin
            x[i] = tiny ? $urandom_range(3, 0) : $urandom_range(24'hFFFFFF, 0);
            y[i] = tiny ? $urandom_range(3, 0) : $urandom_range(24'hFFFFFF, 0);
        end
        return pack_quad(x, y);
    endfunction

    // offer one quad; valid stays high across back-to-back requests
    task automatic send_quad(logic [S_BITS-1:0] q);
        i_s_tdata  <= q;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    task automatic idle_sender(int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_xy(longint x0, longint y0, longint x1, longint y1,
                           longint x2, longint y2, longint x3, longint y3);
        longint x[4], y[4];
        x = '{x0, x1, x2, x3};
        y = '{y0, y1, y2, y3};
        send_quad(pack_quad(x, y));
    endtask

    initial begin
        int burst, sel;
        bit held;
        held = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, extremes, ties, rim, outside, equal X, mirror
        send_xy(0, 0, 0, 0, 0, 0, 0, 0);
        send_xy(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_xy(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                24'h7FFFFF, 24'h800000);
        send_xy(24'hFFFFFF, 0, 0, 24'hFFFFFF, 24'h800000, 24'h800000,
                24'h7FFFFF, 24'h7FFFFF);
        send_xy(0, 0, 2560, 0, 2560, 2560, 0, 2560);
        send_xy(0, 0, 0, 2560, 2560, 2560, 2560, 0);
        send_xy(1, 1, 1, 1, 0, 0, 1, 0);
        send_xy(0, 0, 25600, 25600, 0, 25600, 12800, 12800);
        send_xy(0, 0, 256000, 0, 128000, 153600, 128000, 0);
        send_xy(128000, 0, 0, 0, 128000, 0, 128000, 153600);
        send_xy(0, 0, 25600, 25600, 12800, 10240, 12800, 15360);
        send_xy(0, 0, 12800, 10240, 25600, 25600, 12800, 15360);
        send_xy(0, 0, 25600, 25600, 20480, 17920, 17920, 20480);
        send_xy(25600, 25600, 20480, 17920, 0, 0, 17920, 20480);
        send_xy(5120, 5120, 5120, 10240, 5120, 0, 10240, 5120);
        send_xy(3, 0, 0, 0, 1, 1, 2, 0);
        send_xy(24'hFFFFFF, 0, 24'hFFFFFE, 1, 24'hFFFFFF, 1, 24'hFFFFFE, 0);
        send_xy(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA,
                24'h800000, 24'h800000, 24'h7FFFF0, 24'h800010);

        // pause until every hash is back
        i_s_tvalid <= 1'b0;
        while (sb.pending_hashes.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        // random bursts; one long output hold-off partway through
        while (n_sent < 730) begin
            if (!held && n_sent > 300) begin
                hold_cycles = 120;
                held = 1'b1;
            end
            burst = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10)
                                                : $urandom_range(6, 1);
            for (int i = 0; i < burst; i++) begin
                sel = $urandom_range(19, 0);
                if (sel < 12) send_quad(inner_quad());
                else if (sel < 17) send_quad(noise_quad(1'b0));
                else send_quad(noise_quad(1'b1));
            end
            if ($urandom_range(2, 0) != 0) idle_sender($urandom_range(5, 1));
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending_hashes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d quads, checked %0d hashes (%0d inside the circle).",
                 n_sent, sb.n_checked, sb.n_valid);
        $display("Mismatches: %0d", sb.n_mismatch);
        if (sb.n_mismatch == 0 && sb.pending_hashes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("Timeout with %0d hashes outstanding", sb.pending_hashes.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
